[sv/mcp_pkg.sv]
package mcp_pkg;

  // default sizing of the pool
  localparam int unsigned PIPE_COUNT_DEF = 16;
  localparam int unsigned RING_BYTES_DEF = 256;

  // field widths of the channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DESC_W   = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PIDX_W   = 4;

  // longest run of bytes a single read returns
  localparam int unsigned MAX_RUN = 64;

  // queue depths
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned OFIFO_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_FULL          = 3'd1,
    ST_WOULD_BLOCK   = 3'd2,
    ST_END_OF_DATA   = 3'd3,
    ST_WRONG_END     = 3'd4,
    ST_READER_CLOSED = 3'd5,
    ST_NO_FREE_PIPE  = 3'd6,
    ST_BAD_PIPE      = 3'd7
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_e;

  // decoded command handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [PIDX_W-1:0]   pipe;
    logic                write_end;
    logic [BYTE_W-1:0]   wbyte;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   read_byte;
    logic [PIDX_W-1:0]   pipe_index;
    logic                last;
  } out_item_t;

endpackage

[sv/mcp_in_if.sv]
interface mcp_in_if
  import mcp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [DESC_W-1:0]  descriptor;
  logic [BYTE_W-1:0]  write_byte;
  logic [COUNT_W-1:0] count;

  modport source (
    output valid, kind, descriptor, write_byte, count,
    input  ready
  );

  modport sink (
    input  valid, kind, descriptor, write_byte, count,
    output ready
  );
endinterface

[sv/mcp_out_if.sv]
interface mcp_out_if
  import mcp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic [PIDX_W-1:0]   pipe_index;
  logic                last;

  modport source (
    output valid, status, read_byte, pipe_index, last,
    input  ready
  );

  modport sink (
    input  valid, status, read_byte, pipe_index, last,
    output ready
  );
endinterface

[sv/multi_channel_pipe_fifo_pool.sv]
// Pool of byte pipes kept as rings in one shared single-port-read RAM. Each
// transaction on in_i is decoded by the front end into a two-entry command
// queue; the back end executes one command at a time. A read that returns
// bytes first loads a run, then returns up to 64 bytes, one per cycle while
// the output buffer has room, from the single RAM read port, whose data is
// registered. Results leave through a four-entry output buffer, so the back
// end keeps going while the consumer stalls until that buffer fills; an
// accepted input transaction passes through the command queue, the result
// stage and the output buffer before its result leaves.
// The ring RAM is not cleared after reset and needs no clearing pass.
module multi_channel_pipe_fifo_pool
  import mcp_pkg::*;
#(
  parameter int unsigned PIPE_COUNT = PIPE_COUNT_DEF,
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcp_in_if.sink      in_i,
  mcp_out_if.source   out_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  mcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  mcp_back #(
    .PIPE_COUNT (PIPE_COUNT),
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

[sv/mcp_ram.sv]
module mcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/mcp_front.sv]
module mcp_front
  import mcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcp_in_if.sink      in_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  localparam int unsigned QPW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           q_q [CMDQ_DEPTH];
  logic [QPW-1:0] wr_q, wr_d;
  logic [QPW-1:0] rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  cmd_t           dec;
  logic           push, pop;

  // decode the incoming transaction
  always_comb begin
    dec.kind      = kind_e'(in_i.kind);
    dec.pipe      = in_i.descriptor[DESC_W-1:1];
    dec.write_end = in_i.descriptor[0];
    dec.wbyte     = in_i.write_byte;
    dec.count     = (in_i.count > COUNT_W'(MAX_RUN)) ? COUNT_W'(MAX_RUN) : in_i.count;
  end

  assign in_i.ready  = (cnt_q != QCW'(CMDQ_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= dec;
    end
  end

  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(CMDQ_DEPTH))
    else $error("command queue overflow");

endmodule

[sv/mcp_back.sv]
module mcp_back
  import mcp_pkg::*;
#(
  parameter int unsigned PIPE_COUNT = PIPE_COUNT_DEF,
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  mcp_out_if.source   out_o
);

  localparam int unsigned PIW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int unsigned CW  = $clog2(PIPE_COUNT + 1);
  localparam int unsigned PW  = $clog2(2 * RING_BYTES);
  localparam int unsigned OW  = $clog2(RING_BYTES);
  localparam int unsigned MEM_DEPTH = PIPE_COUNT * RING_BYTES;
  localparam int unsigned AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned OPW = $clog2(OFIFO_DEPTH);
  localparam int unsigned OCW = $clog2(OFIFO_DEPTH + 1);

  // pipe table
  logic [CW-1:0]          opened_q;
  logic [PW-1:0]          wp_q [PIPE_COUNT];
  logic [PW-1:0]          rp_q [PIPE_COUNT];
  logic [PIPE_COUNT-1:0]  ropen_q;
  logic [PIPE_COUNT-1:0]  wopen_q;

  // sequencer
  bk_state_e              state_q, state_d;
  logic [PIDX_W-1:0]      run_pipe_q;
  logic [COUNT_W-1:0]     run_left_q;

  // result stage aligned with the ram read
  logic                   stg_valid_q;
  logic                   stg_mem_q;
  out_item_t              stg_res_q;

  // output buffer
  out_item_t              of_q [OFIFO_DEPTH];
  logic [OPW-1:0]         of_wr_q, of_rd_q;
  logic [OCW-1:0]         of_cnt_q;

  // ram port
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]      mem_rdata;

  logic [PIW-1:0]         cmd_idx, run_idx, cur_idx, open_idx;
  logic [PW-1:0]          wp_cur, rp_cur, fill;
  logic [PW:0]            fill_wrap;
  logic                   pipe_ok, room;
  logic [OCW:0]           used;
  logic [COUNT_W-1:0]     take;

  out_item_t              res;
  logic                   stg_push, res_mem;
  logic                   do_open, do_push, do_pop, do_close, run_load;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(2 * RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [OW-1:0] ptr_off(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= PW'(RING_BYTES)) ? p - PW'(RING_BYTES) : p;
    return OW'(r);
  endfunction

  // pipe lookup
  assign cmd_idx  = PIW'(cmd_i.pipe);
  assign run_idx  = PIW'(run_pipe_q);
  assign open_idx = PIW'(opened_q);
  assign cur_idx  = (state_q == BK_RUN) ? run_idx : cmd_idx;
  assign wp_cur   = wp_q[cur_idx];
  assign rp_cur   = rp_q[cur_idx];
  assign pipe_ok  = (32'(cmd_i.pipe) < 32'(opened_q));

  // ring fill, pointers count modulo twice the ring size
  assign fill_wrap = (PW + 1)'(wp_cur) + (PW + 1)'(2 * RING_BYTES) - (PW + 1)'(rp_cur);
  assign fill      = (wp_cur >= rp_cur) ? wp_cur - rp_cur : PW'(fill_wrap);
  assign take      = (32'(cmd_i.count) < 32'(fill)) ? cmd_i.count : COUNT_W'(fill);

  // space for one more result counting the one in flight
  assign used = (OCW + 1)'(of_cnt_q) + (OCW + 1)'(stg_valid_q);
  assign room = used < (OCW + 1)'(OFIFO_DEPTH);

  // ram addresses
  assign mem_waddr = AW'(cur_idx) * AW'(RING_BYTES) + AW'(ptr_off(wp_cur));
  assign mem_raddr = AW'(cur_idx) * AW'(RING_BYTES) + AW'(ptr_off(rp_cur));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (run_load) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (room && run_left_q == COUNT_W'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // command execution
  always_comb begin
    cmd_ready_o    = 1'b0;
    stg_push       = 1'b0;
    res_mem        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    do_open        = 1'b0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    do_close       = 1'b0;
    run_load       = 1'b0;
    res.status     = ST_OK;
    res.read_byte  = '0;
    res.pipe_index = cmd_i.pipe;
    res.last       = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            KIND_OPEN: begin
              stg_push = 1'b1;
              if (32'(opened_q) >= 32'(PIPE_COUNT)) begin
                res.status     = ST_NO_FREE_PIPE;
                res.pipe_index = '0;
              end else begin
                do_open        = 1'b1;
                res.pipe_index = PIDX_W'(opened_q);
              end
            end
            KIND_WRITE: begin
              stg_push = 1'b1;
              priority if (!cmd_i.write_end) begin
                res.status = ST_WRONG_END;
              end else if (!pipe_ok) begin
                res.status = ST_BAD_PIPE;
              end else if (!ropen_q[cmd_idx]) begin
                res.status = ST_READER_CLOSED;
              end else if (fill >= PW'(RING_BYTES)) begin
                res.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                do_push = 1'b1;
              end
            end
            KIND_READ: begin
              priority if (cmd_i.write_end) begin
                stg_push   = 1'b1;
                res.status = ST_WRONG_END;
              end else if (!pipe_ok) begin
                stg_push   = 1'b1;
                res.status = ST_BAD_PIPE;
              end else if (fill == '0) begin
                stg_push   = 1'b1;
                res.status = wopen_q[cmd_idx] ? ST_WOULD_BLOCK : ST_END_OF_DATA;
              end else if (cmd_i.count == '0) begin
                stg_push   = 1'b1;
              end else begin
                run_load   = 1'b1;
              end
            end
            KIND_CLOSE: begin
              stg_push = 1'b1;
              if (!pipe_ok) begin
                res.status = ST_BAD_PIPE;
              end else begin
                do_close = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        res.pipe_index = run_pipe_q;
        if (room) begin
          mem_re   = 1'b1;
          stg_push = 1'b1;
          res_mem  = 1'b1;
          do_pop   = 1'b1;
          res.last = (run_left_q == COUNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      opened_q    <= '0;
      ropen_q     <= '0;
      wopen_q     <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stg_valid_q <= stg_push;
      if (do_open) begin
        opened_q           <= opened_q + 1'b1;
        ropen_q[open_idx]  <= 1'b1;
        wopen_q[open_idx]  <= 1'b1;
      end
      if (do_close) begin
        if (cmd_i.write_end) begin
          wopen_q[cmd_idx] <= 1'b0;
        end else begin
          ropen_q[cmd_idx] <= 1'b0;
        end
      end
    end
  end

  // pointers and run bookkeeping
  always_ff @(posedge clk_i) begin
    if (do_open) begin
      wp_q[open_idx] <= '0;
      rp_q[open_idx] <= '0;
    end
    if (do_push) begin
      wp_q[cmd_idx] <= ptr_inc(wp_cur);
    end
    if (do_pop) begin
      rp_q[run_idx] <= ptr_inc(rp_cur);
      run_left_q    <= run_left_q - 1'b1;
    end
    if (run_load) begin
      run_pipe_q <= cmd_i.pipe;
      run_left_q <= take;
    end
    if (stg_push) begin
      stg_res_q <= res;
      stg_mem_q <= res_mem;
    end
  end

  mcp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cmd_i.wbyte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output buffer
  logic      of_push, of_pop;
  out_item_t of_in;

  assign of_push = stg_valid_q;
  assign of_pop  = out_o.valid && out_o.ready;

  always_comb begin
    of_in = stg_res_q;
    of_in.read_byte = stg_mem_q ? mem_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= '0;
      of_rd_q  <= '0;
      of_cnt_q <= '0;
    end else begin
      if (of_push) begin
        of_wr_q <= of_wr_q + 1'b1;
      end
      if (of_pop) begin
        of_rd_q <= of_rd_q + 1'b1;
      end
      if (of_push && !of_pop) begin
        of_cnt_q <= of_cnt_q + 1'b1;
      end else if (of_pop && !of_push) begin
        of_cnt_q <= of_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_q[of_wr_q] <= of_in;
    end
  end

  assign out_o.valid      = (of_cnt_q != '0);
  assign out_o.status     = of_q[of_rd_q].status;
  assign out_o.read_byte  = of_q[of_rd_q].read_byte;
  assign out_o.pipe_index = of_q[of_rd_q].pipe_index;
  assign out_o.last       = of_q[of_rd_q].last;

  // a result landing in the buffer always finds a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q |-> (of_cnt_q < OCW'(OFIFO_DEPTH)) || of_pop)
    else $error("output buffer overrun");

  // a read run never sits with nothing left to return
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (run_left_q != '0))
    else $error("empty read run");

  // no ring write while a run owns the ram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("ram read and write in one cycle");

  // the final byte of a run ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && res.last) |=> (state_q == BK_IDLE))
    else $error("run did not end on last byte");

  // pool never hands out more pipes than it has
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(opened_q) <= 32'(PIPE_COUNT))
    else $error("opened count beyond pool size");

endmodule
